@@ rtl/wsp_pkg.sv @@
// Shared types and constants for the WAV stream parser.
// Used by the front parser, the result queue, the back stage and the top level.
`timescale 1ns / 1ps

package wsp_pkg;

   localparam logic [31:0] TAG_RIFF     = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE     = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT      = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
   localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
   localparam logic [15:0] FMT_PCM      = 16'd1;
   localparam logic [15:0] BITS_16      = 16'd16;
   localparam logic [15:0] CHAN_MONO    = 16'd1;
   localparam logic [15:0] CHAN_STEREO  = 16'd2;

   // Positive samples are scaled by 65536/32767 with rounding to nearest.
   localparam logic [16:0] POS_FULL_SCALE = 17'd32767;
   localparam logic [16:0] POS_ROUND_BIAS = 17'd16383;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      PHASE_RIFF,
      PHASE_FSIZE,
      PHASE_WAVE,
      PHASE_CID,
      PHASE_CSIZE,
      PHASE_FMTA,
      PHASE_RATE,
      PHASE_MISC,
      PHASE_BPS,
      PHASE_SKIP,
      PHASE_SAMP,
      PHASE_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_INFO,
      KIND_SAMPLE,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_RIFF,
      ERR_WAVE,
      ERR_FMT_CHUNK,
      ERR_FORMAT,
      ERR_DATA_CHUNK,
      ERR_TRUNCATED
   } err_type;

   // One result as the parser produces it, samples still raw PCM16.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] left_raw;
      logic [15:0] right_raw;
      logic [31:0] sample_rate;
      logic [30:0] sample_count;
      err_type     error_code;
      logic        last;
   } item_type;

   // One result as it leaves the block.
   typedef struct packed {
      kind_type           kind;
      logic signed [17:0] left_sample;
      logic signed [17:0] right_sample;
      logic [31:0]        sample_rate;
      logic [30:0]        sample_count;
      err_type            error_code;
      logic               last;
   } rsp_type;

endpackage

@@ rtl/wav_stream_parser.sv @@
// WAV stream parser, RIFF/WAVE PCM16 in, stream info and Q1.16 stereo samples out.
// Takes one file byte per cycle unless the queue is full; a result passes through the
// two-entry queue and then the result register before it is presented.
// Sustained rate is one byte per cycle, set by the single-byte parser state update.
// Synchronous reset empties the queue and result register and rearms the parser
// to expect the RIFF tag; a byte flagged as end of file rearms it the same way.
`timescale 1ns / 1ps

module wav_stream_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // end_of_file
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [17:0] left_sample, [35:18] right_sample, [67:36] sample_rate,
   // [98:68] sample_count, [101:99] error_code, [103:102] zero
   output logic [103:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // [1:0] kind
   output logic         rsp_tlast    // last
);
   import wsp_pkg::*;

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;
   rsp_type  out_item;

   wsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .data_byte   (req_tdata),
      .end_of_file (req_tlast),
      .push_valid  (push_valid),
      .push_item   (push_item),
      .push_ready  (push_ready)
   );

   wsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   wsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {2'b00, out_item.error_code, out_item.sample_count,
                       out_item.sample_rate, out_item.right_sample, out_item.left_sample};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

endmodule

@@ rtl/wsp_front.sv @@
// Front parser: takes file bytes, walks the RIFF chunks and queues result items.
// Depends on wsp_pkg for the phase, kind, error and item types.
`timescale 1ns / 1ps

module wsp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       data_byte,
   input  logic             end_of_file,
   output logic             push_valid,
   output wsp_pkg::item_type push_item,
   input  logic             push_ready
);
   import wsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [31:0] assembly_ff, assembly_in;
   logic [31:0] chunk_tag_ff, chunk_tag_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic        format_seen_ff, format_seen_in;
   logic        is_stereo_ff, is_stereo_in;
   logic [31:0] rate_ff, rate_in;
   logic [30:0] frames_left_ff, frames_left_in;
   logic [15:0] left_held_ff, left_held_in;

   logic        accept;
   logic [2:0]  idx_inc;
   logic [2:0]  field_len;
   logic [31:0] word;
   logic        field_done;
   logic [30:0] frames_dec;
   logic [30:0] data_frames;
   logic        data_bad;
   logic        fmt_bad;
   logic        ev_valid;
   kind_type    ev_kind;
   err_type     ev_err;
   logic        ev_last;
   logic [15:0] ev_left;
   logic [15:0] ev_right;

   assign in_ready = push_ready;
   assign accept   = in_valid && push_ready;

   // Shared decode of the current byte.
   always_comb begin
      idx_inc = byte_index_ff + 3'd1;
      word    = assembly_ff;
      if (byte_index_ff < 3'd4) begin
         word = assembly_ff | ({24'd0, data_byte} << {byte_index_ff[1:0], 3'b000});
      end
      unique case (phase_ff)
         PHASE_MISC: field_len = 3'd6;
         PHASE_BPS:  field_len = 3'd2;
         default:    field_len = 3'd4;
      endcase
      field_done = (phase_ff != PHASE_SKIP) && (phase_ff != PHASE_SAMP) &&
                   (phase_ff != PHASE_DONE) && (idx_inc >= field_len);
      frames_dec  = frames_left_ff - 31'd1;
      data_frames = is_stereo_ff ? {1'b0, word[31:2]} : word[31:1];
      data_bad    = is_stereo_ff ? (word[1:0] != 2'd0) : word[0];
      fmt_bad     = (chunk_tag_ff[15:0] != FMT_PCM) || (word[15:0] != BITS_16) ||
                    ((chunk_tag_ff[31:16] != CHAN_MONO) &&
                     (chunk_tag_ff[31:16] != CHAN_STEREO));
   end

   // Result event caused by this byte, before the end-of-file check.
   always_comb begin
      ev_valid = 1'b0;
      ev_kind  = KIND_ERROR;
      ev_err   = ERR_NONE;
      ev_last  = 1'b0;
      ev_left  = word[15:0];
      ev_right = word[15:0];
      if (phase_ff == PHASE_SAMP) begin
         if ((idx_inc == 3'd2 && !is_stereo_ff) || idx_inc >= 3'd4) begin
            ev_valid = 1'b1;
            ev_kind  = KIND_SAMPLE;
            ev_last  = (frames_dec == 31'd0);
            if (is_stereo_ff) begin
               ev_left  = left_held_ff;
               ev_right = word[31:16];
            end
         end
      end else if (field_done) begin
         unique case (phase_ff)
            PHASE_RIFF: begin
               if (word != TAG_RIFF) begin
                  ev_valid = 1'b1;
                  ev_err   = ERR_RIFF;
               end
            end
            PHASE_WAVE: begin
               if (word != TAG_WAVE) begin
                  ev_valid = 1'b1;
                  ev_err   = ERR_WAVE;
               end
            end
            PHASE_CSIZE: begin
               if (chunk_tag_ff == TAG_FMT) begin
                  if (format_seen_ff || word < FMT_MIN_SIZE) begin
                     ev_valid = 1'b1;
                     ev_err   = ERR_FMT_CHUNK;
                  end
               end else if (chunk_tag_ff == TAG_DATA) begin
                  ev_valid = 1'b1;
                  if (!format_seen_ff || data_bad) begin
                     ev_err = ERR_DATA_CHUNK;
                  end else begin
                     ev_kind = KIND_INFO;
                  end
               end
            end
            PHASE_BPS: begin
               if (fmt_bad) begin
                  ev_valid = 1'b1;
                  ev_err   = ERR_FORMAT;
               end
            end
            default: begin
            end
         endcase
         // Errors always end the file; an info ends it only for an empty data chunk.
         ev_last = (ev_kind == KIND_INFO) ? (data_frames == 31'd0) : 1'b1;
      end
   end

   // Next state of the parser.
   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      assembly_in    = assembly_ff;
      chunk_tag_in   = chunk_tag_ff;
      bytes_left_in  = bytes_left_ff;
      format_seen_in = format_seen_ff;
      is_stereo_in   = is_stereo_ff;
      rate_in        = rate_ff;
      frames_left_in = frames_left_ff;
      left_held_in   = left_held_ff;
      if (accept && phase_ff != PHASE_DONE) begin
         if (phase_ff == PHASE_SKIP) begin
            bytes_left_in = bytes_left_ff - 32'd1;
            if (bytes_left_ff == 32'd1) begin
               phase_in = PHASE_CID;
            end
         end else begin
            byte_index_in = idx_inc;
            assembly_in   = word;
            if (phase_ff == PHASE_SAMP) begin
               if (ev_valid) begin
                  frames_left_in = frames_dec;
                  byte_index_in  = 3'd0;
                  assembly_in    = 32'd0;
               end else if (idx_inc == 3'd2) begin
                  left_held_in = word[15:0];
               end
            end else if (field_done) begin
               byte_index_in = 3'd0;
               assembly_in   = 32'd0;
               unique case (phase_ff)
                  PHASE_RIFF:  phase_in = PHASE_FSIZE;
                  PHASE_FSIZE: phase_in = PHASE_WAVE;
                  PHASE_WAVE:  phase_in = PHASE_CID;
                  PHASE_CID: begin
                     chunk_tag_in = word;
                     phase_in     = PHASE_CSIZE;
                  end
                  PHASE_CSIZE: begin
                     if (chunk_tag_ff == TAG_FMT) begin
                        format_seen_in = 1'b1;
                        bytes_left_in  = word - FMT_MIN_SIZE;
                        phase_in       = PHASE_FMTA;
                     end else if (chunk_tag_ff == TAG_DATA) begin
                        frames_left_in = data_frames;
                        phase_in       = PHASE_SAMP;
                     end else begin
                        bytes_left_in = word;
                        phase_in      = (word != 32'd0) ? PHASE_SKIP : PHASE_CID;
                     end
                  end
                  // The fmt body reuses the chunk tag for format and channel count.
                  PHASE_FMTA: begin
                     chunk_tag_in = word;
                     phase_in     = PHASE_RATE;
                  end
                  PHASE_RATE: begin
                     rate_in  = word;
                     phase_in = PHASE_MISC;
                  end
                  PHASE_MISC: phase_in = PHASE_BPS;
                  PHASE_BPS: begin
                     is_stereo_in = (chunk_tag_ff[31:16] == CHAN_STEREO);
                     phase_in     = (bytes_left_ff != 32'd0) ? PHASE_SKIP : PHASE_CID;
                  end
                  default: phase_in = PHASE_DONE;
               endcase
            end
            if (ev_valid && ev_last) begin
               phase_in = PHASE_DONE;
            end
         end
      end
      // The final byte of a file always rearms the parser.
      if (accept && end_of_file) begin
         phase_in       = PHASE_RIFF;
         byte_index_in  = 3'd0;
         assembly_in    = 32'd0;
         chunk_tag_in   = 32'd0;
         bytes_left_in  = 32'd0;
         format_seen_in = 1'b0;
         is_stereo_in   = 1'b0;
         rate_in        = 32'd0;
         frames_left_in = 31'd0;
         left_held_in   = 16'd0;
      end
   end

   // Request to the queue.
   always_comb begin
      push_valid             = 1'b0;
      push_item.kind         = ev_kind;
      push_item.left_raw     = 16'd0;
      push_item.right_raw    = 16'd0;
      push_item.sample_rate  = 32'd0;
      push_item.sample_count = 31'd0;
      push_item.error_code   = ERR_NONE;
      push_item.last         = ev_last;
      if (accept && phase_ff != PHASE_DONE) begin
         if (end_of_file && !(ev_valid && ev_last)) begin
            // A file that ends anywhere but after its last result is truncated.
            push_valid           = 1'b1;
            push_item.kind       = KIND_ERROR;
            push_item.error_code = ERR_TRUNCATED;
            push_item.last       = 1'b1;
         end else if (ev_valid) begin
            push_valid = 1'b1;
            unique case (ev_kind)
               KIND_SAMPLE: begin
                  push_item.left_raw  = ev_left;
                  push_item.right_raw = ev_right;
               end
               KIND_INFO: begin
                  push_item.sample_rate  = rate_ff;
                  push_item.sample_count = data_frames;
               end
               default: push_item.error_code = ev_err;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_RIFF;
         byte_index_ff  <= 3'd0;
         assembly_ff    <= 32'd0;
         chunk_tag_ff   <= 32'd0;
         bytes_left_ff  <= 32'd0;
         format_seen_ff <= 1'b0;
         is_stereo_ff   <= 1'b0;
         rate_ff        <= 32'd0;
         frames_left_ff <= 31'd0;
         left_held_ff   <= 16'd0;
      end else begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         assembly_ff    <= assembly_in;
         chunk_tag_ff   <= chunk_tag_in;
         bytes_left_ff  <= bytes_left_in;
         format_seen_ff <= format_seen_in;
         is_stereo_ff   <= is_stereo_in;
         rate_ff        <= rate_in;
         frames_left_ff <= frames_left_in;
         left_held_ff   <= left_held_in;
      end
   end

endmodule

@@ rtl/wsp_queue.sv @@
// Short queue of parsed result items between the front parser and the back stage.
// Depends on wsp_pkg for the item type and the queue depth.
`timescale 1ns / 1ps

module wsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  wsp_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output wsp_pkg::item_type pop_item,
   input  logic              pop_ready
);
   import wsp_pkg::*;

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/wsp_back.sv @@
// Back stage: scales raw PCM16 samples to Q1.16 and holds the result register.
// Depends on wsp_pkg for the item and result types and the scaling constants.
`timescale 1ns / 1ps

module wsp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  wsp_pkg::item_type pop_item,
   output logic              pop_ready,
   output logic              out_valid,
   output wsp_pkg::rsp_type  out_item,
   input  logic              out_ready
);
   import wsp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type item_ff, item_in;
   logic    load;

   // Negative values double; positive v gives 2v + round(2v / 32767), where the
   // quotient of (2v + 16383) by 32767 is at most two and found by two compares.
   function automatic logic signed [17:0] to_q16(input logic [15:0] v);
      logic [16:0] t;
      logic [1:0]  q;
      t = {v, 1'b0} + POS_ROUND_BIAS;
      q = {1'b0, (t >= POS_FULL_SCALE)} + {1'b0, (t >= {POS_FULL_SCALE[15:0], 1'b0})};
      if (v[15]) begin
         to_q16 = {1'b1, v, 1'b0};
      end else begin
         to_q16 = {1'b0, v, 1'b0} + {16'd0, q};
      end
   endfunction

   assign pop_ready = !valid_ff || out_ready;
   assign load      = pop_valid && pop_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      item_in.kind         = pop_item.kind;
      item_in.left_sample  = 18'sd0;
      item_in.right_sample = 18'sd0;
      item_in.sample_rate  = pop_item.sample_rate;
      item_in.sample_count = pop_item.sample_count;
      item_in.error_code   = pop_item.error_code;
      item_in.last         = pop_item.last;
      if (pop_item.kind == KIND_SAMPLE) begin
         item_in.left_sample  = to_q16(pop_item.left_raw);
         item_in.right_sample = to_q16(pop_item.right_raw);
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ test/wav_stream_parser_test.sv @@
// Self-checking testbench for the WAV stream parser: drives whole and broken WAV files as
// byte requests and checks every result against a cycle-free prediction of the parser.
// Depends on wsp_pkg for the result layout, tags and codes, and on wav_stream_parser.
`timescale 1ns / 1ps

module wav_stream_parser_test;
   import wsp_pkg::*;

   localparam logic [31:0] JUNK_TAG   = 32'h5453_494C;
   localparam logic [15:0] FMT_FLOAT  = 16'd3;
   localparam logic [15:0] BITS_8     = 16'd8;
   localparam logic [15:0] CHAN_NONE  = 16'd0;
   localparam logic [15:0] CHAN_THREE = 16'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   wav_stream_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted parser state.
   phase_type   p_phase;
   int          p_idx;
   logic [31:0] p_word;
   logic [31:0] p_tag;
   logic [31:0] p_left;
   logic        p_fmt_seen;
   logic        p_stereo;
   logic [31:0] p_rate;
   logic [30:0] p_frames;
   logic [15:0] p_left_held;

   rsp_type    parsed_results[$];
   logic [7:0] wav_bytes[$];
   int         mismatches = 0;
   bit         gaps_on = 1'b1;
   bit         stalls_on = 1'b1;
   int         ready_hold = 0;

   function automatic void parser_rearm();
      p_phase     = PHASE_RIFF;
      p_idx       = 0;
      p_word      = '0;
      p_tag       = '0;
      p_left      = '0;
      p_fmt_seen  = 1'b0;
      p_stereo    = 1'b0;
      p_rate      = '0;
      p_frames    = '0;
      p_left_held = '0;
   endfunction

   initial parser_rearm();

   // Negative samples are doubled; positive ones scale by 65536/32767, rounded to nearest.
   function automatic logic [17:0] to_fixed(input logic [15:0] v);
      logic [31:0] scaled;
      if (v[15])
         return {1'b1, v, 1'b0};
      scaled = ({16'd0, v} << 16) + 32'd16383;
      return 18'(scaled / 32'd32767);
   endfunction

   function automatic bit fail_with(input err_type code, output rsp_type r);
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      r.last       = 1'b1;
      p_phase      = PHASE_DONE;
      return 1'b1;
   endfunction

   function automatic bit emit_frame(input logic [15:0] l, input logic [15:0] rt,
                                     output rsp_type r);
      r              = '0;
      r.kind         = KIND_SAMPLE;
      r.left_sample  = to_fixed(l);
      r.right_sample = to_fixed(rt);
      p_frames       = p_frames - 31'd1;
      p_idx          = 0;
      p_word         = '0;
      r.last         = (p_frames == 31'd0);
      if (p_frames == 31'd0)
         p_phase = PHASE_DONE;
      return 1'b1;
   endfunction

   function automatic bit finish_field(input logic [31:0] w, output rsp_type r);
      logic [15:0] code;
      logic [15:0] chans;
      logic [30:0] frames;
      r = '0;
      case (p_phase)
         PHASE_RIFF: begin
            if (w != TAG_RIFF)
               return fail_with(ERR_RIFF, r);
            p_phase = PHASE_FSIZE;
         end
         PHASE_FSIZE: p_phase = PHASE_WAVE;
         PHASE_WAVE: begin
            if (w != TAG_WAVE)
               return fail_with(ERR_WAVE, r);
            p_phase = PHASE_CID;
         end
         PHASE_CID: begin
            p_tag   = w;
            p_phase = PHASE_CSIZE;
         end
         PHASE_CSIZE: begin
            if (p_tag == TAG_FMT) begin
               if (p_fmt_seen || w < FMT_MIN_SIZE)
                  return fail_with(ERR_FMT_CHUNK, r);
               p_fmt_seen = 1'b1;
               p_left     = w - FMT_MIN_SIZE;
               p_phase    = PHASE_FMTA;
            end else if (p_tag == TAG_DATA) begin
               if (!p_fmt_seen)
                  return fail_with(ERR_DATA_CHUNK, r);
               if (p_stereo ? (w[1:0] != 2'd0) : w[0])
                  return fail_with(ERR_DATA_CHUNK, r);
               frames        = p_stereo ? 31'(w >> 2) : 31'(w >> 1);
               p_frames      = frames;
               r.kind        = KIND_INFO;
               r.sample_rate = p_rate;
               r.sample_count = frames;
               r.last        = (frames == 31'd0);
               p_phase       = (frames == 31'd0) ? PHASE_DONE : PHASE_SAMP;
               return 1'b1;
            end else begin
               p_left  = w;
               p_phase = (w != 32'd0) ? PHASE_SKIP : PHASE_CID;
            end
         end
         PHASE_FMTA: begin
            p_tag   = w;
            p_phase = PHASE_RATE;
         end
         PHASE_RATE: begin
            p_rate  = w;
            p_phase = PHASE_MISC;
         end
         PHASE_MISC: p_phase = PHASE_BPS;
         PHASE_BPS: begin
            code  = p_tag[15:0];
            chans = p_tag[31:16];
            if (code != FMT_PCM || w[15:0] != BITS_16 ||
                (chans != CHAN_MONO && chans != CHAN_STEREO))
               return fail_with(ERR_FORMAT, r);
            p_stereo = (chans == CHAN_STEREO);
            p_phase  = (p_left != 32'd0) ? PHASE_SKIP : PHASE_CID;
         end
         default: p_phase = PHASE_DONE;
      endcase
      return 1'b0;
   endfunction

   // Advances the predicted state by one file byte; returns 1 when a result is due.
   function automatic bit parse_byte(input logic [7:0] b, input logic eof, output rsp_type r);
      bit          made;
      logic [31:0] w;
      made = 1'b0;
      r    = '0;
      if (p_phase == PHASE_DONE) begin
         if (eof)
            parser_rearm();
         return 1'b0;
      end
      if (p_phase == PHASE_SKIP) begin
         p_left = p_left - 32'd1;
         if (p_left == 32'd0)
            p_phase = PHASE_CID;
      end else begin
         if (p_idx < 4)
            p_word = p_word | (32'(b) << (8 * p_idx));
         p_idx++;
         if (p_phase == PHASE_SAMP) begin
            if (p_idx == 2) begin
               if (!p_stereo)
                  made = emit_frame(p_word[15:0], p_word[15:0], r);
               else
                  p_left_held = p_word[15:0];
            end else if (p_idx >= 4) begin
               made = emit_frame(p_left_held, p_word[31:16], r);
            end
         end else if (p_idx >= ((p_phase == PHASE_MISC) ? 6 : (p_phase == PHASE_BPS) ? 2 : 4))
         begin
            w      = p_word;
            p_idx  = 0;
            p_word = '0;
            made   = finish_field(w, r);
         end
      end
      // The final byte of a file reports truncation unless it already closed the stream.
      if (eof) begin
         if (!(made && r.last) && p_phase != PHASE_DONE)
            made = fail_with(ERR_TRUNCATED, r);
         parser_rearm();
      end
      return made;
   endfunction

   always @(posedge clock) begin : request_watch
      rsp_type r;
      if (!reset && req_tvalid && req_tready) begin
         if (parse_byte(req_tdata, req_tlast, r))
            parsed_results.push_back(r);
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("time %0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (parsed_results.size() == 0) begin
            mismatches++;
            $display("time %0t: unexpected result, expected none, actual kind %0d data %h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            want = parsed_results.pop_front();
            compare_field("kind", {30'd0, want.kind}, {30'd0, rsp_tuser});
            compare_field("left_sample", {14'd0, want.left_sample}, {14'd0, rsp_tdata[17:0]});
            compare_field("right_sample", {14'd0, want.right_sample},
                          {14'd0, rsp_tdata[35:18]});
            compare_field("sample_rate", want.sample_rate, rsp_tdata[67:36]);
            compare_field("sample_count", {1'b0, want.sample_count}, {1'b0, rsp_tdata[98:68]});
            compare_field("error_code", {29'd0, want.error_code}, {29'd0, rsp_tdata[101:99]});
            compare_field("last", {31'd0, want.last}, {31'd0, rsp_tlast});
         end
      end
   end

   // Receiver stalls come in bursts of random length.
   always @(negedge clock) begin
      if (stalls_on && ready_hold > 0) begin
         ready_hold--;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
         ready_hold = $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         ready_hold = 0;
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eof);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_file();
      int n;
      n = wav_bytes.size();
      for (int k = 0; k < n; k++)
         send_byte(wav_bytes[k], k == n - 1);
      wav_bytes.delete();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (parsed_results.size() != 0)
         @(negedge clock);
   endtask

   function automatic void put_le(input logic [31:0] w, input int n);
      for (int k = 0; k < n; k++)
         wav_bytes.push_back(w[8 * k +: 8]);
   endfunction

   function automatic void put_riff(input logic [31:0] wave_tag);
      put_le(TAG_RIFF, 4);
      put_le($urandom, 4);
      put_le(wave_tag, 4);
   endfunction

   function automatic void put_fmt(input logic [31:0] size, input logic [15:0] code,
                                   input logic [15:0] chans, input logic [31:0] rate,
                                   input logic [15:0] bits);
      put_le(TAG_FMT, 4);
      put_le(size, 4);
      put_le({chans, code}, 4);
      put_le(rate, 4);
      put_le($urandom, 4);
      put_le($urandom, 2);
      put_le(bits, 2);
      if (size > FMT_MIN_SIZE && size < 32'd64)
         for (int k = 16; k < int'(size); k++)
            put_le($urandom, 1);
   endfunction

   function automatic void put_chunk(input logic [31:0] tag, input int size);
      put_le(tag, 4);
      put_le(size, 4);
      for (int k = 0; k < size; k++)
         put_le($urandom, 1);
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void put_samples(input int n);
      for (int k = 0; k < n; k++)
         put_le(pick_sample(), 2);
   endfunction

   function automatic void put_data_head(input logic [31:0] size);
      put_le(TAG_DATA, 4);
      put_le(size, 4);
   endfunction

   task automatic test_mono_extremes();
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_MONO, 32'hFFFF_FFFF, BITS_16);
      put_data_head(32'd12);
      put_le(16'h0000, 2);
      put_le(16'h0001, 2);
      put_le(16'h7FFF, 2);
      put_le(16'h8000, 2);
      put_le(16'hFFFF, 2);
      put_le(16'h4000, 2);
      send_file();
   endtask

   task automatic test_stereo_layout();
      // Odd-sized and empty unknown chunks, a long fmt, and bytes left after the last frame.
      put_riff(TAG_WAVE);
      put_chunk(JUNK_TAG, 3);
      put_fmt(32'd18, FMT_PCM, CHAN_STEREO, 32'd44100, BITS_16);
      put_chunk(JUNK_TAG, 0);
      put_data_head(32'd8);
      put_le(32'h8000_7FFF, 4);
      put_samples(2);
      put_le($urandom, 3);
      send_file();
      // An empty data chunk closes the stream with its info result.
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_STEREO, 32'd0, BITS_16);
      put_data_head(32'd0);
      send_file();
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_MONO, 32'd8000, BITS_16);
      put_data_head(32'd0);
      put_le($urandom, 2);
      send_file();
   endtask

   task automatic test_header_errors();
      put_le(TAG_RIFF ^ 32'h0100_0000, 4);
      put_le($urandom, 4);
      send_file();
      put_riff(TAG_WAVE ^ 32'h0000_0080);
      put_le($urandom, 2);
      send_file();
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_MONO, 32'd22050, BITS_16);
      put_fmt(32'd16, FMT_PCM, CHAN_MONO, 32'd22050, BITS_16);
      send_file();
      put_riff(TAG_WAVE);
      put_fmt(32'd15, FMT_PCM, CHAN_MONO, 32'd22050, BITS_16);
      send_file();
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_FLOAT, CHAN_MONO, 32'd48000, BITS_16);
      put_le($urandom, 1);
      send_file();
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_STEREO, 32'd48000, BITS_8);
      put_le($urandom, 1);
      send_file();
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_NONE, 32'd48000, BITS_16);
      put_le($urandom, 1);
      send_file();
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_THREE, 32'd48000, BITS_16);
      put_le($urandom, 1);
      send_file();
      put_riff(TAG_WAVE);
      put_data_head(32'd4);
      put_le($urandom, 1);
      send_file();
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_MONO, 32'd11025, BITS_16);
      put_data_head(32'hFFFF_FFFF);
      put_le($urandom, 1);
      send_file();
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_STEREO, 32'd11025, BITS_16);
      put_data_head(32'd6);
      put_le($urandom, 1);
      send_file();
   endtask

   task automatic test_truncation();
      put_le($urandom, 1);
      send_file();
      // No data chunk at all.
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_MONO, 32'd32000, BITS_16);
      send_file();
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_MONO, 32'd32000, BITS_16);
      put_le(JUNK_TAG, 4);
      put_le(32'd9, 4);
      put_le($urandom, 4);
      send_file();
      // A format error on the final byte is reported as such, not as truncation.
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_MONO, 32'd32000, BITS_8);
      send_file();
      // Largest frame counts, cut short inside the samples.
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_MONO, 32'h8000_0000, BITS_16);
      put_data_head(32'hFFFF_FFFE);
      put_samples(2);
      send_file();
      put_riff(TAG_WAVE);
      put_fmt(32'd16, FMT_PCM, CHAN_STEREO, 32'd96000, BITS_16);
      put_data_head(32'hFFFF_FFFC);
      put_samples(2);
      put_le($urandom, 1);
      send_file();
   endtask

   function automatic void build_random_file();
      logic [15:0] chans;
      int          words;
      int          cut;
      chans = $urandom_range(0, 1) ? CHAN_STEREO : CHAN_MONO;
      words = $urandom_range(0, 6) * ((chans == CHAN_STEREO) ? 2 : 1);
      put_riff(TAG_WAVE);
      if ($urandom_range(0, 3) == 0)
         put_chunk(JUNK_TAG ^ {24'd0, 8'($urandom_range(1, 255))}, $urandom_range(0, 5));
      put_fmt(($urandom_range(0, 3) == 0) ? 32'd16 + $urandom_range(1, 4) : 32'd16,
              FMT_PCM, chans, $urandom, BITS_16);
      if ($urandom_range(0, 4) == 0)
         put_chunk(JUNK_TAG, $urandom_range(0, 5));
      put_data_head(words * 2);
      put_samples(words);
      if ($urandom_range(0, 5) == 0)
         put_le($urandom, $urandom_range(1, 3));
      // About half of the files are damaged, cut short or replaced by noise.
      case ($urandom_range(0, 9))
         0, 1: wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] ^= 8'($urandom_range(1, 255));
         2, 3: begin
            cut = $urandom_range(1, wav_bytes.size() - 1);
            while (wav_bytes.size() > cut)
               void'(wav_bytes.pop_back());
         end
         4: begin
            wav_bytes.delete();
            put_le($urandom, 0);
            for (int k = $urandom_range(1, 12); k > 0; k--)
               put_le($urandom, 1);
         end
         default: ;
      endcase
   endfunction

   task automatic test_random_files();
      int  items;
      bit  paused;
      items  = 0;
      paused = 1'b0;
      while (items < 450) begin
         gaps_on   = (items < 340) && ($urandom_range(0, 3) != 0);
         stalls_on = (items < 340) && ($urandom_range(0, 3) != 0);
         build_random_file();
         items += wav_bytes.size();
         send_file();
         if (!paused && items >= 225) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_mono_extremes();
      test_stereo_layout();
      test_header_errors();
      test_truncation();
      wait_drained();
      test_random_files();
      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && parsed_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
rtl/wsp_pkg.sv
rtl/wsp_front.sv
rtl/wsp_queue.sv
rtl/wsp_back.sv
rtl/wav_stream_parser.sv
test/wav_stream_parser_test.sv
